[sv/imhq_pkg.sv]
// shared types and constants for the indexed min-heap queue
// used by imhq_posmap, indexed_min_heap_queue and the bench; depends on nothing
`default_nettype none
package imhq_pkg;

  localparam int DEPTH_DEF    = 128;
  localparam int KEY_BITS_DEF = 31;
  localparam int ID_W         = 7;
  localparam int ID_COUNT     = 128;
  localparam int KEY_PORT_W   = 31;
  localparam int CNT_PORT_W   = 8;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_DEC  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DEC1, S_UP, S_UP2, S_POP1, S_POP2,
    S_DN, S_DN2, S_DN3, S_FIN, S_TOP, S_DONE
  } state_t;

endpackage
`default_nettype wire

[sv/imhq_ram.sv]
// heap slot memory: one write port, one read port, registered read data
// depends on nothing
`default_nettype none
module imhq_ram #(
  parameter int AW    = 8,
  parameter int DW    = 38,
  parameter int WORDS = 129
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/imhq_posmap.sv]
// id to slot map: memory plus per-id valid bits, an invalid id reads as absent
// depends on imhq_pkg
`default_nettype none
module imhq_posmap #(
  parameter int PW = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    we,
  input  wire logic [imhq_pkg::ID_W-1:0] waddr,
  input  wire logic [PW-1:0]           wdata,
  input  wire logic [imhq_pkg::ID_W-1:0] raddr,
  output logic      [PW-1:0]           rdata
);

  logic [PW-1:0] mem [imhq_pkg::ID_COUNT];
  logic [imhq_pkg::ID_COUNT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= vld_r[raddr] ? mem[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[sv/indexed_min_heap_queue.sv]
// Indexed binary min-heap of (key, id) pairs with decrease-key. One word in
// gives one word out. The pairs live in a one-port-read slot memory and the
// id map in a second memory; every heap level of a sift up is a read, then
// a compare and write back, and a pop's sift down adds a second read per
// level for the right child, when present. A new word is taken while the
// previous result still waits at the output.
// depends on imhq_pkg, imhq_ram, imhq_posmap
`default_nettype none
module indexed_min_heap_queue #(
  parameter int DEPTH    = imhq_pkg::DEPTH_DEF,
  parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_func,
  input  wire logic [imhq_pkg::KEY_PORT_W-1:0]   in_key,
  input  wire logic [imhq_pkg::ID_W-1:0]         in_item_id,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [2:0]                             out_status,
  output logic [imhq_pkg::KEY_PORT_W-1:0]        out_removed_key,
  output logic [imhq_pkg::ID_W-1:0]              out_removed_id,
  output logic [imhq_pkg::KEY_PORT_W-1:0]        out_top_key,
  output logic [imhq_pkg::ID_W-1:0]              out_top_id,
  output logic                                   out_heap_empty,
  output logic [imhq_pkg::CNT_PORT_W-1:0]        out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = imhq_pkg::ID_W;
  localparam int EW = KEY_BITS + IW;
  localparam int KP = imhq_pkg::KEY_PORT_W;
  localparam int OC = imhq_pkg::CNT_PORT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);

  imhq_pkg::state_t  state_r, state_nxt;
  imhq_pkg::func_t   func_r, func_nxt;
  imhq_pkg::status_t status_r, status_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [IW-1:0]       id_r, id_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       bslot_r, bslot_nxt;
  logic [EW-1:0]       m_r, m_nxt;
  logic [EW-1:0]       best_r, best_nxt;
  logic [EW-1:0]       rem_r, rem_nxt;
  logic [EW-1:0]       top_r, top_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          o_status_r, o_status_nxt;
  logic [EW-1:0]       o_rem_r, o_rem_nxt;
  logic [EW-1:0]       o_top_r, o_top_nxt;
  logic [CW-1:0]       o_cnt_r, o_cnt_nxt;

  logic          heap_we;
  logic [CW-1:0] heap_waddr, heap_raddr;
  logic [EW-1:0] heap_wdata, heap_rdata;
  logic          pos_we;
  logic [IW-1:0] pos_waddr, pos_raddr;
  logic [CW-1:0] pos_wdata, pos_rdata;

  logic [KEY_BITS+KP-1:0] key_ext;
  logic [CW:0]            lc, rc;
  logic [EW-1:0]          cand;
  logic [CW-1:0]          cslot;
  logic                   take;

  imhq_ram #(.AW(CW), .DW(EW), .WORDS(DEPTH + 1)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  imhq_posmap #(.PW(CW)) u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign key_ext = {{KEY_BITS{1'b0}}, in_key};
  assign lc      = {i_r, 1'b0};
  assign rc      = lc + (CW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imhq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    status_r   <= status_nxt;
    key_r      <= key_nxt;
    id_r       <= id_nxt;
    i_r        <= i_nxt;
    bslot_r    <= bslot_nxt;
    m_r        <= m_nxt;
    best_r     <= best_nxt;
    rem_r      <= rem_nxt;
    top_r      <= top_nxt;
    o_status_r <= o_status_nxt;
    o_rem_r    <= o_rem_nxt;
    o_top_r    <= o_top_nxt;
    o_cnt_r    <= o_cnt_nxt;
  end

  // child pick for sift down: right child only when present and smaller
  always_comb begin
    if (state_r == imhq_pkg::S_DN3 && heap_rdata < best_r) begin
      cand  = heap_rdata;
      cslot = rc[CW-1:0];
    end else if (state_r == imhq_pkg::S_DN3) begin
      cand  = best_r;
      cslot = bslot_r;
    end else begin
      cand  = heap_rdata;
      cslot = lc[CW-1:0];
    end
    take = cand < m_r;
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    status_nxt    = status_r;
    key_nxt       = key_r;
    id_nxt        = id_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    bslot_nxt     = bslot_r;
    m_nxt         = m_r;
    best_nxt      = best_r;
    rem_nxt       = rem_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_status_nxt  = o_status_r;
    o_rem_nxt     = o_rem_r;
    o_top_nxt     = o_top_r;
    o_cnt_nxt     = o_cnt_r;
    in_stall      = (state_r != imhq_pkg::S_IDLE);
    heap_we       = 1'b0;
    heap_waddr    = i_r;
    heap_wdata    = m_r;
    heap_raddr    = ONE;
    pos_we        = 1'b0;
    pos_waddr     = m_r[IW-1:0];
    pos_wdata     = i_r;
    pos_raddr     = in_item_id;

    case (state_r)
      imhq_pkg::S_IDLE: begin
        if (in_valid) begin
          func_nxt   = imhq_pkg::func_t'(in_func);
          key_nxt    = key_ext[KEY_BITS-1:0];
          id_nxt     = in_item_id;
          status_nxt = imhq_pkg::ST_OK;
          rem_nxt    = '0;
          state_nxt  = imhq_pkg::S_LOOK;
        end
      end
      imhq_pkg::S_LOOK: begin
        case (func_r)
          imhq_pkg::FUNC_PUSH: begin
            if (count_r == FULL_CNT) begin
              status_nxt = imhq_pkg::ST_FULL;
              state_nxt  = imhq_pkg::S_FIN;
            end else if (pos_rdata != '0) begin
              status_nxt = imhq_pkg::ST_DUP;
              state_nxt  = imhq_pkg::S_FIN;
            end else begin
              count_nxt = count_r + ONE;
              i_nxt     = count_r + ONE;
              m_nxt     = {key_r, id_r};
              state_nxt = imhq_pkg::S_UP;
            end
          end
          imhq_pkg::FUNC_POP: begin
            if (count_r == '0) begin
              status_nxt = imhq_pkg::ST_EMPTY;
              state_nxt  = imhq_pkg::S_FIN;
            end else begin
              heap_raddr = ONE;
              state_nxt  = imhq_pkg::S_POP1;
            end
          end
          imhq_pkg::FUNC_DEC: begin
            if (pos_rdata == '0 || pos_rdata > count_r) begin
              status_nxt = imhq_pkg::ST_ABSENT;
              state_nxt  = imhq_pkg::S_FIN;
            end else begin
              heap_raddr = pos_rdata;
              i_nxt      = pos_rdata;
              state_nxt  = imhq_pkg::S_DEC1;
            end
          end
          default: state_nxt = imhq_pkg::S_FIN;
        endcase
      end
      imhq_pkg::S_DEC1: begin
        if (key_r < heap_rdata[EW-1:IW]) begin
          m_nxt     = {key_r, id_r};
          state_nxt = imhq_pkg::S_UP;
        end else begin
          state_nxt = imhq_pkg::S_FIN;
        end
      end
      imhq_pkg::S_UP: begin
        if (i_r == ONE) begin
          heap_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = imhq_pkg::S_FIN;
        end else begin
          heap_raddr = i_r >> 1;
          state_nxt  = imhq_pkg::S_UP2;
        end
      end
      imhq_pkg::S_UP2: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (m_r < heap_rdata) begin
          // parent moves down into the hole
          heap_wdata = heap_rdata;
          pos_waddr  = heap_rdata[IW-1:0];
          i_nxt      = i_r >> 1;
          state_nxt  = imhq_pkg::S_UP;
        end else begin
          state_nxt = imhq_pkg::S_FIN;
        end
      end
      imhq_pkg::S_POP1: begin
        rem_nxt   = heap_rdata;
        pos_we    = 1'b1;
        pos_waddr = heap_rdata[IW-1:0];
        pos_wdata = '0;
        count_nxt = count_r - ONE;
        if (count_r == ONE) begin
          state_nxt = imhq_pkg::S_FIN;
        end else begin
          heap_raddr = count_r;
          state_nxt  = imhq_pkg::S_POP2;
        end
      end
      imhq_pkg::S_POP2: begin
        m_nxt     = heap_rdata;
        i_nxt     = ONE;
        state_nxt = imhq_pkg::S_DN;
      end
      imhq_pkg::S_DN: begin
        if (lc > {1'b0, count_r}) begin
          heap_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = imhq_pkg::S_FIN;
        end else begin
          heap_raddr = lc[CW-1:0];
          state_nxt  = imhq_pkg::S_DN2;
        end
      end
      imhq_pkg::S_DN2, imhq_pkg::S_DN3: begin
        if (state_r == imhq_pkg::S_DN2 && rc <= {1'b0, count_r}) begin
          heap_raddr = rc[CW-1:0];
          best_nxt   = heap_rdata;
          bslot_nxt  = lc[CW-1:0];
          state_nxt  = imhq_pkg::S_DN3;
        end else begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
          if (take) begin
            // smaller child moves up into the hole
            heap_wdata = cand;
            pos_waddr  = cand[IW-1:0];
            i_nxt      = cslot;
            state_nxt  = imhq_pkg::S_DN;
          end else begin
            state_nxt = imhq_pkg::S_FIN;
          end
        end
      end
      imhq_pkg::S_FIN: begin
        heap_raddr = ONE;
        state_nxt  = imhq_pkg::S_TOP;
      end
      imhq_pkg::S_TOP: begin
        top_nxt   = (count_r != '0) ? heap_rdata : '0;
        state_nxt = imhq_pkg::S_DONE;
      end
      imhq_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_rem_nxt     = rem_r;
          o_top_nxt     = top_r;
          o_cnt_nxt     = count_r;
          state_nxt     = imhq_pkg::S_IDLE;
        end
      end
      default: state_nxt = imhq_pkg::S_IDLE;
    endcase
  end

  logic [KP+KEY_BITS-1:0] rem_key_ext, top_key_ext;
  logic [OC+CW-1:0]       cnt_ext;

  assign rem_key_ext = {{KP{1'b0}}, o_rem_r[EW-1:IW]};
  assign top_key_ext = {{KP{1'b0}}, o_top_r[EW-1:IW]};
  assign cnt_ext     = {{OC{1'b0}}, o_cnt_r};

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_removed_key = rem_key_ext[KP-1:0];
  assign out_removed_id  = o_rem_r[IW-1:0];
  assign out_top_key     = top_key_ext[KP-1:0];
  assign out_top_id      = o_top_r[IW-1:0];
  assign out_heap_empty  = (o_cnt_r == '0);
  assign out_entry_count = cnt_ext[OC-1:0];

endmodule
`default_nettype wire

[verif/tb_top.sv]
// self-checking bench for the indexed min-heap queue: directed table, a fill past capacity, then random words
// depends on imhq_pkg and indexed_min_heap_queue
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int HEAP_MAX = imhq_pkg::DEPTH_DEF;
  localparam int TAIL_ITEMS = 150;

  typedef struct packed {
    imhq_pkg::func_t func;
    logic [30:0] key;
    logic [6:0] item_id;
  } op_word_t;

  typedef struct packed {
    imhq_pkg::status_t status;
    logic [30:0] removed_key;
    logic [6:0] removed_id;
    logic [30:0] top_key;
    logic [6:0] top_id;
    logic heap_empty;
    logic [7:0] entry_count;
  } heap_report_t;

  typedef struct {
    op_word_t word;
    bit known;
    heap_report_t report;
  } table_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_func;
  logic [30:0] in_key;
  logic [6:0] in_item_id;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_status;
  logic [30:0] out_removed_key;
  logic [6:0] out_removed_id;
  logic [30:0] out_top_key;
  logic [6:0] out_top_id;
  logic out_heap_empty;
  logic [7:0] out_entry_count;

  indexed_min_heap_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_key(in_key), .in_item_id(in_item_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_removed_key(out_removed_key),
    .out_removed_id(out_removed_id), .out_top_key(out_top_key),
    .out_top_id(out_top_id), .out_heap_empty(out_heap_empty),
    .out_entry_count(out_entry_count)
  );

  // predictor state, slots numbered from 1
  logic [30:0] slot_key [1:HEAP_MAX];
  logic [6:0] slot_id [1:HEAP_MAX];
  int unsigned slot_of_id [0:imhq_pkg::ID_COUNT-1];
  int unsigned held;

  heap_report_t pending_reports[$];
  int error_count;
  bit tail_phase;
  bit hold_off;
  int sent_items;

  function automatic bit slot_lt(int unsigned a, int unsigned b);
    if (slot_key[a] != slot_key[b]) return slot_key[a] < slot_key[b];
    return slot_id[a] < slot_id[b];
  endfunction

  function automatic void slot_exchange(int unsigned a, int unsigned b);
    logic [30:0] k;
    logic [6:0] d;
    k = slot_key[a];
    d = slot_id[a];
    slot_key[a] = slot_key[b];
    slot_id[a] = slot_id[b];
    slot_key[b] = k;
    slot_id[b] = d;
    slot_of_id[slot_id[a]] = a;
    slot_of_id[slot_id[b]] = b;
  endfunction

  function automatic void bubble_up(int unsigned i);
    while (i > 1 && slot_lt(i, i >> 1)) begin
      slot_exchange(i, i >> 1);
      i = i >> 1;
    end
  endfunction

  function automatic void bubble_down(int unsigned i);
    int unsigned s;
    forever begin
      s = i;
      if (2 * i <= held && slot_lt(2 * i, s)) s = 2 * i;
      if (2 * i + 1 <= held && slot_lt(2 * i + 1, s)) s = 2 * i + 1;
      if (s == i) break;
      slot_exchange(i, s);
      i = s;
    end
  endfunction

  function automatic heap_report_t apply_heap_op(op_word_t w);
    heap_report_t r;
    int unsigned loc;
    r = '0;
    r.status = imhq_pkg::ST_OK;
    case (w.func)
      imhq_pkg::FUNC_PUSH: begin
        if (held >= HEAP_MAX) r.status = imhq_pkg::ST_FULL;
        else if (slot_of_id[w.item_id] != 0) r.status = imhq_pkg::ST_DUP;
        else begin
          held++;
          slot_key[held] = w.key;
          slot_id[held] = w.item_id;
          slot_of_id[w.item_id] = held;
          bubble_up(held);
        end
      end
      imhq_pkg::FUNC_POP: begin
        if (held == 0) r.status = imhq_pkg::ST_EMPTY;
        else begin
          r.removed_key = slot_key[1];
          r.removed_id = slot_id[1];
          slot_exchange(1, held);
          slot_of_id[r.removed_id] = 0;
          held--;
          bubble_down(1);
        end
      end
      imhq_pkg::FUNC_DEC: begin
        loc = slot_of_id[w.item_id];
        if (loc == 0 || loc > held) r.status = imhq_pkg::ST_ABSENT;
        else if (w.key < slot_key[loc]) begin
          slot_key[loc] = w.key;
          bubble_up(loc);
        end
      end
      default: ;
    endcase
    if (held > 0) begin
      r.top_key = slot_key[1];
      r.top_id = slot_id[1];
    end else r.heap_empty = 1'b1;
    r.entry_count = held[7:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

  // random idle burst length, none in the tail
  function automatic int idle_burst();
    if (tail_phase || $urandom_range(3) != 0) return 0;
    return $urandom_range(12, 1);
  endfunction

  task automatic send_word(op_word_t w, bit known, heap_report_t want);
    heap_report_t got;
    int gap;
    gap = idle_burst();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= w.func;
    in_key <= w.key;
    in_item_id <= w.item_id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = apply_heap_op(w);
    pending_reports.push_back(known ? want : got);
    sent_items++;
    @(negedge clk);
  endtask

  function automatic op_word_t random_word();
    op_word_t w;
    int pick;
    w.key = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(63));
    w.item_id = 7'($urandom);
    pick = $urandom_range(99);
    // lean towards pushes so the heap fills and empties
    if (pick < 45) w.func = imhq_pkg::FUNC_PUSH;
    else if (pick < 80) w.func = imhq_pkg::FUNC_POP;
    else if (pick < 97) w.func = imhq_pkg::FUNC_DEC;
    else w.func = imhq_pkg::FUNC_NONE;
    // decrease-key mostly aims at a held id
    if (w.func == imhq_pkg::FUNC_DEC && held > 0 && $urandom_range(4) != 0)
      w.item_id = slot_id[$urandom_range(held, 1)];
    return w;
  endfunction

  // result side: random stall bursts plus one long hold-off
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
        continue;
      end
      gap = idle_burst();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    heap_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result word");
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_status != want.status) begin
          $error("status exp %0d got %0d", want.status, out_status); error_count++; end
        if (out_removed_key != want.removed_key) begin
          $error("removed_key exp %0d got %0d", want.removed_key, out_removed_key);
          error_count++; end
        if (out_removed_id != want.removed_id) begin
          $error("removed_id exp %0d got %0d", want.removed_id, out_removed_id);
          error_count++; end
        if (out_top_key != want.top_key) begin
          $error("top_key exp %0d got %0d", want.top_key, out_top_key); error_count++; end
        if (out_top_id != want.top_id) begin
          $error("top_id exp %0d got %0d", want.top_id, out_top_id); error_count++; end
        if (out_heap_empty != want.heap_empty) begin
          $error("heap_empty exp %0d got %0d", want.heap_empty, out_heap_empty);
          error_count++; end
        if (out_entry_count != want.entry_count) begin
          $error("entry_count exp %0d got %0d", want.entry_count, out_entry_count);
          error_count++; end
      end
    end
  end

  function automatic table_row_t row(imhq_pkg::func_t f, logic [30:0] k, logic [6:0] d,
                                     bit known, imhq_pkg::status_t st, logic [30:0] tk,
                                     logic [6:0] td, logic [7:0] cnt);
    table_row_t t;
    t.word = '{func: f, key: k, item_id: d};
    t.known = known;
    t.report = '0;
    t.report.status = st;
    t.report.top_key = tk;
    t.report.top_id = td;
    t.report.heap_empty = cnt == 0;
    t.report.entry_count = cnt;
    return t;
  endfunction

  initial begin
    table_row_t stim[$];
    op_word_t w;
    int waited;
    error_count = 0;
    sent_items = 0;
    tail_phase = 1'b0;
    hold_off = 1'b0;
    held = 0;
    foreach (slot_of_id[i]) slot_of_id[i] = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = imhq_pkg::FUNC_NONE;
    in_key = '0;
    in_item_id = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pop, absent id, extremes, duplicate, ties, ignored key
    stim.push_back(row(imhq_pkg::FUNC_POP, 0, 0, 1, imhq_pkg::ST_EMPTY, 0, 0, 0));
    stim.push_back(row(imhq_pkg::FUNC_DEC, 5, 9, 1, imhq_pkg::ST_ABSENT, 0, 0, 0));
    stim.push_back(row(imhq_pkg::FUNC_NONE, '1, '1, 1, imhq_pkg::ST_OK, 0, 0, 0));
    stim.push_back(row(imhq_pkg::FUNC_PUSH, '1, '1, 1, imhq_pkg::ST_OK, '1, '1, 1));
    stim.push_back(row(imhq_pkg::FUNC_PUSH, '1, 0, 1, imhq_pkg::ST_OK, '1, 0, 2));
    stim.push_back(row(imhq_pkg::FUNC_PUSH, 7, 127, 1, imhq_pkg::ST_DUP, '1, 0, 2));
    stim.push_back(row(imhq_pkg::FUNC_PUSH, 0, 64, 1, imhq_pkg::ST_OK, 0, 64, 3));
    stim.push_back(row(imhq_pkg::FUNC_PUSH, 0, 3, 1, imhq_pkg::ST_OK, 0, 3, 4));
    stim.push_back(row(imhq_pkg::FUNC_DEC, '1, 127, 1, imhq_pkg::ST_OK, 0, 3, 4));
    stim.push_back(row(imhq_pkg::FUNC_DEC, 0, 127, 1, imhq_pkg::ST_OK, 0, 3, 4));
    stim.push_back(row(imhq_pkg::FUNC_DEC, 5, 0, 0, imhq_pkg::ST_OK, 0, 0, 0));
    stim.push_back(row(imhq_pkg::FUNC_NONE, 0, 0, 0, imhq_pkg::ST_OK, 0, 0, 0));
    for (int i = 0; i < 4; i++)
      stim.push_back(row(imhq_pkg::FUNC_POP, 0, 0, 0, imhq_pkg::ST_OK, 0, 0, 0));
    stim.push_back(row(imhq_pkg::FUNC_POP, 0, 0, 1, imhq_pkg::ST_EMPTY, 0, 0, 0));
    stim.push_back(row(imhq_pkg::FUNC_PUSH, 31'h2AAAAAAA, 7'h55, 0, imhq_pkg::ST_OK, 0, 0, 0));
    stim.push_back(row(imhq_pkg::FUNC_PUSH, 31'h55555555, 7'h2A, 0, imhq_pkg::ST_OK, 0, 0, 0));
    foreach (stim[i]) send_word(stim[i].word, stim[i].known, stim[i].report);

    // fill to capacity and beyond
    for (int i = 0; i < imhq_pkg::ID_COUNT; i++) begin
      w.func = imhq_pkg::FUNC_PUSH;
      w.key = 31'($urandom_range(40));
      w.item_id = 7'(i);
      send_word(w, 0, '0);
    end
    w.func = imhq_pkg::FUNC_PUSH;
    w.item_id = 7'h11;
    send_word(w, 0, '0);
    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    for (int i = 0; i < 90; i++) send_word(random_word(), 0, '0);

    while (sent_items < 1250) begin
      if (sent_items >= 1250 - TAIL_ITEMS) tail_phase = 1'b1;
      send_word(random_word(), 0, '0);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_reports.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
